@@ src/md5hc_pkg.sv @@
// md5hc_pkg: shared types, opcodes and MD5 constant tables for the
// MD5 hash-chain random generator. No dependencies.

package md5hc_pkg;

   typedef enum logic [1:0] {
      OP_UDRAW   = 2'd0,
      OP_SDRAW   = 2'd1,
      OP_DISCARD = 2'd2,
      OP_RESEED  = 2'd3
   } opcode_type;

   localparam int ROUNDS = 64;

   localparam logic [31:0] MD5_IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] MD5_K [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] MD5_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word index for a round
   function automatic logic [3:0] md5_g(input logic [5:0] r);
      logic [3:0] q;
      logic [3:0] g;
      q = r[3:0];
      case (r[5:4])
         2'd0: g = q;
         2'd1: g = (q << 2) + q + 4'd1;
         2'd2: g = (q << 1) + q + 4'd5;
         2'd3: g = (q << 3) - q;
         default: g = q;
      endcase
      return g;
   endfunction

   typedef struct packed {
      logic       load_seed;
      logic       start;
      logic       round_en;
      logic [5:0] round_idx;
      logic       digest;
      logic       mul;
      logic       signed_op;
      logic       out_load;
   } md5hc_cmd_type;

   typedef struct packed {
      logic out_busy;
   } md5hc_status_type;

endpackage

@@ src/md5hc_csr.sv @@
// md5hc_csr: APB-style register block holding the two 64-bit seed registers.
// Depends on nothing else.

module md5hc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready,
   output logic [63:0] seed_low,
   output logic [63:0] seed_high
);

   localparam logic [3:0] REG_SEED_LOW  = 4'h0;
   localparam logic [3:0] REG_SEED_HIGH = 4'h8;

   logic [63:0] seed_low_ff,  seed_low_in;
   logic [63:0] seed_high_ff, seed_high_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      seed_low_in  = seed_low_ff;
      seed_high_in = seed_high_ff;
      if (wr_en) begin
         case (csr_paddr)
            REG_SEED_LOW:  seed_low_in  = csr_pwdata;
            REG_SEED_HIGH: seed_high_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_low_ff  <= '0;
         seed_high_ff <= '0;
      end else begin
         seed_low_ff  <= seed_low_in;
         seed_high_ff <= seed_high_in;
      end
   end

   assign csr_prdata = (csr_paddr == REG_SEED_HIGH) ? seed_high_ff :
                       (csr_paddr == REG_SEED_LOW)  ? seed_low_ff  : '0;
   assign seed_low   = seed_low_ff;
   assign seed_high  = seed_high_ff;

endmodule

@@ src/md5hc_ctrl.sv @@
// md5hc_ctrl: sequencer for accept, 64 MD5 rounds, digest, scaling and output.
// Depends on md5hc_pkg.

module md5hc_ctrl
   import md5hc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_opcode,
   output logic             req_ready,
   input  md5hc_status_type status,
   output md5hc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_DIGEST,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] round_ff, round_in;
   opcode_type op_ff, op_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.round_idx = round_ff;
      cmd.signed_op = (op_ff == OP_SDRAW);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = opcode_type'(req_opcode);
               if (opcode_type'(req_opcode) == OP_RESEED) begin
                  cmd.load_seed = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  round_in  = '0;
                  state_in  = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_DIGEST;
            end
         end
         ST_DIGEST: begin
            cmd.digest = 1'b1;
            state_in   = (op_ff == OP_DISCARD) ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         op_ff    <= OP_UDRAW;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         op_ff    <= op_in;
      end
   end

endmodule

@@ src/md5hc_dpath.sv @@
// md5hc_dpath: accumulator, MD5 round unit, scaling multiplier and output word
// register. Depends on md5hc_pkg; driven by md5hc_ctrl.

module md5hc_dpath
   import md5hc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  md5hc_cmd_type    cmd,
   output md5hc_status_type status,
   input  logic [31:0]      req_bound,
   input  logic [63:0]      seed_low,
   input  logic [63:0]      seed_high,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_value
);

   logic [31:0] acc_ff   [4];
   logic [31:0] acc_in   [4];
   logic [31:0] state_ff [4];
   logic [31:0] state_in [4];
   logic [31:0] bound_ff, bound_in;
   logic [63:0] prod_ff,  prod_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] f, m, t, rot, word, mag;
   logic [3:0]  g;
   logic [4:0]  s;

   // one MD5 round
   always_comb begin
      case (cmd.round_idx[5:4])
         2'd0: f = (state_ff[1] & state_ff[2]) | (~state_ff[1] & state_ff[3]);
         2'd1: f = (state_ff[3] & state_ff[1]) | (~state_ff[3] & state_ff[2]);
         2'd2: f = state_ff[1] ^ state_ff[2] ^ state_ff[3];
         2'd3: f = state_ff[2] ^ (state_ff[1] | ~state_ff[3]);
         default: f = '0;
      endcase
      g = md5_g(cmd.round_idx);
      // padded single block: accumulator, 0x80 marker, bit length 128
      case (g)
         4'd0, 4'd1, 4'd2, 4'd3: m = acc_ff[g[1:0]];
         4'd4:  m = 32'h0000_0080;
         4'd14: m = 32'd128;
         default: m = '0;
      endcase
      s   = MD5_S[{cmd.round_idx[5:4], cmd.round_idx[1:0]}];
      t   = state_ff[0] + f + MD5_K[cmd.round_idx] + m;
      rot = (t << s) | (t >> (6'd32 - 6'(s)));
   end

   assign word = acc_ff[0];
   always_comb begin
      if (word == 32'h8000_0000) begin
         mag = 32'h7fff_ffff;
      end else if (word[31]) begin
         mag = ~word + 32'd1;
      end else begin
         mag = word;
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      state_in     = state_ff;
      bound_in     = bound_ff;
      prod_in      = prod_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.load_seed) begin
         acc_in[0] = seed_low[31:0];
         acc_in[1] = seed_low[63:32];
         acc_in[2] = seed_high[31:0];
         acc_in[3] = seed_high[63:32];
      end
      if (cmd.start) begin
         state_in = MD5_IV;
         bound_in = req_bound;
      end
      if (cmd.round_en) begin
         state_in[0] = state_ff[3];
         state_in[3] = state_ff[2];
         state_in[2] = state_ff[1];
         state_in[1] = state_ff[1] + rot;
      end
      if (cmd.digest) begin
         for (int i = 0; i < 4; i++) begin
            acc_in[i] = MD5_IV[i] + state_ff[i];
         end
      end
      if (cmd.mul) begin
         prod_in = (cmd.signed_op ? mag : word) * bound_ff;
      end
      if (cmd.out_load) begin
         rsp_value_in = cmd.signed_op ? prod_ff[62:31] : prod_ff[63:32];
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '{default: '0};
         state_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bound_ff     <= bound_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign status.out_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;

endmodule

@@ src/md5_hash_chain_random_generator.sv @@
// md5_hash_chain_random_generator: top level of the MD5 hash-chain generator.
// Depends on md5hc_pkg, md5hc_csr, md5hc_ctrl and md5hc_dpath.
//
//   channel  direction  payload                                    handshake
//   req      in         tdata: bound[31:0]; tuser: opcode[1:0]     tvalid/tready
//   rsp      out        tdata: value[31:0]                         tvalid/tready
//   csr      in/out     seed_low @0x0, seed_high @0x8, 64 bit      APB, pready high
//
// Discards run the one-round-a-cycle MD5 loop and then the digest add
// before ready returns; draws add the multiply and the load of the output
// register. A reseed loads the accumulator from the seeds without leaving idle.
// A word waiting in the output register does not block the next accept; a
// draw finishing while it still waits holds in its last step until taken.
// Reset is synchronous and clears accumulator, seeds and handshake state.

module md5_hash_chain_random_generator
   import md5hc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // bound[31:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value[31:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   md5hc_cmd_type    cmd;
   md5hc_status_type status;
   logic [63:0]      seed_low, seed_high;

   md5hc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seed_low    (seed_low),
      .seed_high   (seed_high)
   );

   md5hc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   md5hc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_bound (req_tdata),
      .seed_low  (seed_low),
      .seed_high (seed_high),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_tdata)
   );

endmodule

@@ src/md5hc_checker.sv @@
// md5hc_checker: port-level assertions for md5_hash_chain_random_generator,
// bound to the top level. Depends on md5hc_pkg.

module md5hc_checker
   import md5hc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_pready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // a hashing opcode keeps the input side busy for the rounds
   a_busy_after_hash: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != OP_RESEED) |=> !req_tready)
      else $error("input accepted again straight after a hashing opcode");

   // a reseed leaves the input side ready again in the cycle after
   a_reseed_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_RESEED) |=> req_tready)
      else $error("reseed left the input side busy");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("handshake not cleared by reset");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("register port not ready");

endmodule

bind md5_hash_chain_random_generator md5hc_checker u_md5hc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

@@ tb/tb_md5_hash_chain_random_generator.sv @@
`timescale 1ns / 1ps
// tb_md5_hash_chain_random_generator: self-checking bench for the MD5 hash-chain generator.
// Runs draw, discard and reseed words through an in-bench MD5 chain and checks every value.
// Depends on md5hc_pkg and md5_hash_chain_random_generator.

module tb_md5_hash_chain_random_generator;
   import md5hc_pkg::*;

   localparam int GAP_MAX       = 18;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_WORDS  = 1000;
   localparam int PHASES        = 6;

   localparam logic [3:0] ADDR_SEED_LOW  = 4'h0;
   localparam logic [3:0] ADDR_SEED_HIGH = 4'h8;

   localparam logic [31:0] CHAIN_IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int unsigned ROUND_ROT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   typedef struct packed {
      opcode_type  op;
      logic [31:0] bound;
   } gen_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // bound[31:0]
   logic [1:0]  req_tuser = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // value[31:0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   gen_word_type req_backlog [$];
   logic [31:0]  expected_values [$];

   logic [31:0] chain_acc [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
   logic [63:0] seed_lo = '0;
   logic [63:0] seed_hi = '0;

   bit          req_fire = 1'b0;
   bit          rsp_fire = 1'b0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          req_gap = 0;
   int          rsp_wait = 0;
   int          cycles = 0;
   int          mismatches = 0;
   logic [31:0] oldest_value;

   md5_hash_chain_random_generator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // one MD5 block over the 16 accumulator bytes; chain_acc becomes the digest
   function automatic void advance_chain();
      logic [31:0] msg [16];
      logic [31:0] a, b, c, d, f, t, held;
      int unsigned g, s;
      for (int i = 0; i < 16; i++) msg[i] = 32'h0;
      for (int i = 0; i < 4; i++) msg[i] = chain_acc[i];
      msg[4]  = 32'h00000080;
      msg[14] = 32'd128;
      a = CHAIN_IV[0];
      b = CHAIN_IV[1];
      c = CHAIN_IV[2];
      d = CHAIN_IV[3];
      for (int unsigned r = 0; r < 64; r++) begin
         if (r < 16) begin
            f = (b & c) | (~b & d);
            g = r;
         end else if (r < 32) begin
            f = (d & b) | (~d & c);
            g = (5 * r + 1) % 16;
         end else if (r < 48) begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
         end else begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
         end
         t = a + f + ROUND_K[r] + msg[g];
         s = ROUND_ROT[((r >> 4) << 2) | (r & 3)];
         held = d;
         d = c;
         c = b;
         b = b + ((t << s) | (t >> (32 - s)));
         a = held;
      end
      chain_acc[0] = CHAIN_IV[0] + a;
      chain_acc[1] = CHAIN_IV[1] + b;
      chain_acc[2] = CHAIN_IV[2] + c;
      chain_acc[3] = CHAIN_IV[3] + d;
   endfunction

   function automatic void predict_value(input opcode_type op, input logic [31:0] bound);
      logic [31:0] word;
      logic [31:0] mag;
      logic [63:0] prod;
      if (op == OP_RESEED) begin
         chain_acc[0] = seed_lo[31:0];
         chain_acc[1] = seed_lo[63:32];
         chain_acc[2] = seed_hi[31:0];
         chain_acc[3] = seed_hi[63:32];
      end else begin
         advance_chain();
         word = chain_acc[0];
         if (op == OP_UDRAW) begin
            prod = {32'h0, word} * {32'h0, bound};
            expected_values.push_back(prod[63:32]);
         end else if (op == OP_SDRAW) begin
            // most negative word saturates to the largest magnitude
            if (word == 32'h80000000) mag = 32'h7fffffff;
            else if (word[31]) mag = 32'h0 - word;
            else mag = word;
            prod = {32'h0, mag} * {32'h0, bound};
            expected_values.push_back(prod[62:31]);
         end
      end
   endfunction

   function automatic int idle_draw(input bit calm);
      return calm ? 0 : int'($urandom_range(0, GAP_MAX));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch: %s, expected %h, got %h, cycle %0d", what, want, got, cycles);
      mismatches++;
   endtask

   // monitor and scoreboard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fire) begin
         if (expected_values.size() == 0) begin
            report_mismatch("value with nothing pending", 32'h0, rsp_tdata);
         end else begin
            oldest_value = expected_values.pop_front();
            if (rsp_tdata !== oldest_value)
               report_mismatch("value", oldest_value, rsp_tdata);
         end
      end
      if (req_fire) predict_value(opcode_type'(req_tuser), req_tdata);
   end

   // request driver
   always @(negedge clock) begin : req_drive
      logic         next_valid;
      gen_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (next_valid && req_fire) begin
            next_valid = 1'b0;
            req_gap = idle_draw(req_calm);
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (req_backlog.size() > 0) begin
               w = req_backlog.pop_front();
               req_tdata <= w.bound;
               req_tuser <= w.op;
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_wait = idle_draw(rsp_calm);
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_word(input opcode_type op, input logic [31:0] bound);
      gen_word_type w;
      w.op = op;
      w.bound = bound;
      req_backlog.push_back(w);
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_tvalid || expected_values.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_SEED_LOW) seed_lo = data;
      else seed_hi = data;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [63:0] pick_seed();
      case ($urandom_range(0, 5))
         0: return 64'h0;
         1: return '1;
         2: return 64'h8000000000000000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic gen_word_type pick_word();
      gen_word_type w;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 42) w.op = OP_UDRAW;
      else if (r < 84) w.op = OP_SDRAW;
      else if (r < 94) w.op = OP_DISCARD;
      else w.op = OP_RESEED;
      case ($urandom_range(0, 7))
         0: w.bound = 32'h0;
         1: w.bound = 32'hffffffff;
         2: w.bound = $urandom_range(0, 15);
         3: w.bound = 32'h1 << $urandom_range(0, 31);
         default: w.bound = $urandom;
      endcase
      return w;
   endfunction

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // straight from reset: zero accumulator and zero seeds
      push_word(OP_UDRAW, 32'hffffffff);
      push_word(OP_UDRAW, 32'h0);
      push_word(OP_SDRAW, 32'hffffffff);
      push_word(OP_SDRAW, 32'h0);
      push_word(OP_UDRAW, 32'h1);
      push_word(OP_SDRAW, 32'h1);
      push_word(OP_UDRAW, 32'h80000000);
      push_word(OP_SDRAW, 32'h80000000);
      push_word(OP_DISCARD, 32'hffffffff);
      push_word(OP_DISCARD, 32'h0);
      push_word(OP_RESEED, 32'h0);
      push_word(OP_UDRAW, 32'hffffffff);
      push_word(OP_RESEED, 32'hffffffff);
      push_word(OP_SDRAW, 32'h7fffffff);
      push_word(OP_UDRAW, 32'h7fffffff);
      wait_idle();

      csr_write(ADDR_SEED_LOW, '1);
      csr_write(ADDR_SEED_HIGH, '1);
      push_word(OP_RESEED, 32'h0);
      push_word(OP_UDRAW, 32'hffffffff);
      push_word(OP_SDRAW, 32'hffffffff);
      push_word(OP_DISCARD, 32'h12345678);
      push_word(OP_UDRAW, 32'h0);
      wait_idle();

      csr_write(ADDR_SEED_LOW, 64'h0);
      csr_write(ADDR_SEED_HIGH, 64'h8000000000000001);
      push_word(OP_RESEED, 32'h0);
      push_word(OP_SDRAW, 32'hffffffff);
      push_word(OP_UDRAW, 32'hfffffffe);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         csr_write(ADDR_SEED_LOW, pick_seed());
         csr_write(ADDR_SEED_HIGH, pick_seed());
         push_word(OP_RESEED, $urandom);
         for (int i = 0; i < RANDOM_WORDS / PHASES; i++)
            req_backlog.push_back(pick_word());
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("tb_md5_hash_chain_random_generator: clean");
      end else begin
         $display("tb_md5_hash_chain_random_generator: errors");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("timeout at cycle %0d", cycles);
      $display("tb_md5_hash_chain_random_generator: errors");
      $finish;
   end

endmodule

@@ sim.f @@
src/md5hc_pkg.sv
src/md5hc_csr.sv
src/md5hc_ctrl.sv
src/md5hc_dpath.sv
src/md5_hash_chain_random_generator.sv
src/md5hc_checker.sv
tb/tb_md5_hash_chain_random_generator.sv
